// ===== hw/rtl/qvr_pkg.sv =====
// shared widths, types and latency of the quaternion vector rotator
package qvr_pkg;
    localparam int QW        = 16;          // quaternion component
    localparam int VW        = 32;          // vector coordinate
    localparam int SW        = 2 * QW;      // component product
    localparam int MW        = SW + 2;      // rotation matrix entry
    localparam int PW        = MW + VW;     // entry times coordinate
    localparam int AW        = PW + 2;      // sum of three products
    localparam int NW        = SW + 1;      // squared length
    localparam int GW        = PW;          // rounded magnitude of the numerator
    localparam int DIV_STEPS = NW;          // quotient bits
    localparam int LATENCY   = 2 + 3 + DIV_STEPS + 1;

    typedef logic signed [QW-1:0] t_quat;
    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [MW-1:0] t_ment;
    typedef logic        [NW-1:0] t_norm;
    typedef logic        [GW-1:0] t_mag;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;
endpackage

// ===== hw/rtl/quaternion_vector_rotate.sv =====
// top level: rotates a vector by a quaternion sandwich product, one beat a cycle
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  command  | start / busy       | i_quat_w..i_quat_z (Q2.14), i_vec_x..z (Q16.16)
//  result   | o_valid strobe     | o_rot_x..o_rot_z (Q16.16), o_zero_quat, o_saturated
//
//  a beat is taken every cycle; busy is held low since nothing ever stalls
//  each result passes these registered stages after its command beat:
//  2 matrix stages, 3 row stages, 33 divider stages (one quotient bit each), 1 output
//  the 33-step quotient chain sets the depth, not the rate
//  synchronous active-low reset clears the valid bits; in-flight beats are dropped
//  the receiver cannot hold results off, so a result shows for exactly one cycle
module quaternion_vector_rotate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  i_quat_w,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  logic signed [31:0]  i_vec_z,
    output logic                o_valid,
    output logic signed [31:0]  o_rot_x,
    output logic signed [31:0]  o_rot_y,
    output logic signed [31:0]  o_rot_z,
    output logic                o_zero_quat,
    output logic                o_saturated
);
    import qvr_pkg::*;

    t_quat q_in [4];
    t_vec  v_in [3];

    // matrix front end
    t_ctl  mx_ctl;
    t_norm mx_n;
    t_ment mx_m [3][3];
    t_vec  mx_v [3];

    // per coordinate lanes
    t_ctl  rw_ctl [3];
    t_norm rw_n   [3];
    t_mag  rw_mag [3];
    logic  rw_neg [3];
    t_ctl  dv_ctl [3];
    t_vec  dv_rot [3];
    logic  dv_sat [3];

    assign q_in[0] = i_quat_w;
    assign q_in[1] = i_quat_x;
    assign q_in[2] = i_quat_y;
    assign q_in[3] = i_quat_z;
    assign v_in[0] = i_vec_x;
    assign v_in[1] = i_vec_y;
    assign v_in[2] = i_vec_z;

    // no back pressure anywhere, so every start is a beat
    assign busy = 1'b0;

    qvr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_q     (q_in),
        .i_v     (v_in),
        .o_ctl   (mx_ctl),
        .o_n     (mx_n),
        .o_m     (mx_m),
        .o_v     (mx_v)
    );

    for (genvar r = 0; r < 3; r++) begin : g_lane
        qvr_row u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (mx_ctl),
            .i_n     (mx_n),
            .i_m     (mx_m[r]),
            .i_v     (mx_v),
            .o_ctl   (rw_ctl[r]),
            .o_n     (rw_n[r]),
            .o_mag   (rw_mag[r]),
            .o_neg   (rw_neg[r])
        );

        qvr_divider u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (rw_ctl[r]),
            .i_n     (rw_n[r]),
            .i_mag   (rw_mag[r]),
            .i_neg   (rw_neg[r]),
            .o_ctl   (dv_ctl[r]),
            .o_rot   (dv_rot[r]),
            .o_sat   (dv_sat[r])
        );
    end

    // all lanes run in lock step; lane 0 carries the strobe and zero flag
    assign o_valid     = dv_ctl[0].valid;
    assign o_zero_quat = dv_ctl[0].zero;
    assign o_rot_x     = dv_rot[0];
    assign o_rot_y     = dv_rot[1];
    assign o_rot_z     = dv_rot[2];
    assign o_saturated = dv_sat[0] | dv_sat[1] | dv_sat[2];

    // every command beat gives a result strobe once it has passed the whole pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("result strobe missing after command beat");

    // the three lanes never drift apart
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_ctl[0] == dv_ctl[1] && dv_ctl[0] == dv_ctl[2])
        else $error("coordinate lanes out of step");

    // zero quaternion gives a zero vector and no clipping
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_quat |-> o_rot_x == '0 && o_rot_y == '0 && o_rot_z == '0
                                   && !o_saturated)
        else $error("zero quaternion result not cleared");

    // a clipped x lane sits on one of the two bounds
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && dv_sat[0] |-> o_rot_x == 32'sh7FFF_FFFF || o_rot_x == 32'sh8000_0000)
        else $error("clipped coordinate off its bound");
endmodule

// ===== hw/rtl/qvr_matrix.sv =====
// squares, cross products, squared length and unnormalized rotation matrix
module qvr_matrix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  qvr_pkg::t_quat i_q [4],
    input  qvr_pkg::t_vec  i_v [3],
    output qvr_pkg::t_ctl  o_ctl,
    output qvr_pkg::t_norm o_n,
    output qvr_pkg::t_ment o_m [3][3],
    output qvr_pkg::t_vec  o_v [3]
);
    import qvr_pkg::*;

    // order: w, x, y, z
    logic signed [SW-1:0] r_sq [4];
    // order: xy, wz, xz, wy, yz, wx
    logic signed [SW-1:0] r_cr [6];
    t_vec                 r_v1 [3];
    logic                 r_val1;

    t_norm n_n;
    t_ment r_m [3][3];
    t_norm r_n;
    t_vec  r_v2 [3];
    t_ctl  r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val1 <= 1'b0;
        end else begin
            r_val1 <= i_valid;
        end
        for (int i = 0; i < 4; i++) begin
            r_sq[i] <= i_q[i] * i_q[i];
        end
        r_cr[0] <= i_q[1] * i_q[2];
        r_cr[1] <= i_q[0] * i_q[3];
        r_cr[2] <= i_q[1] * i_q[3];
        r_cr[3] <= i_q[0] * i_q[2];
        r_cr[4] <= i_q[2] * i_q[3];
        r_cr[5] <= i_q[0] * i_q[1];
        r_v1    <= i_v;
    end

    assign n_n = NW'(unsigned'(r_sq[0])) + NW'(unsigned'(r_sq[1]))
               + NW'(unsigned'(r_sq[2])) + NW'(unsigned'(r_sq[3]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= r_val1;
            r_ctl.zero  <= (n_n == '0);
        end
        r_n     <= n_n;
        r_v2    <= r_v1;
        r_m[0][0] <= MW'(r_sq[0]) + MW'(r_sq[1]) - MW'(r_sq[2]) - MW'(r_sq[3]);
        r_m[1][1] <= MW'(r_sq[0]) - MW'(r_sq[1]) + MW'(r_sq[2]) - MW'(r_sq[3]);
        r_m[2][2] <= MW'(r_sq[0]) - MW'(r_sq[1]) - MW'(r_sq[2]) + MW'(r_sq[3]);
        r_m[0][1] <= (MW'(r_cr[0]) - MW'(r_cr[1])) <<< 1;
        r_m[1][0] <= (MW'(r_cr[0]) + MW'(r_cr[1])) <<< 1;
        r_m[0][2] <= (MW'(r_cr[2]) + MW'(r_cr[3])) <<< 1;
        r_m[2][0] <= (MW'(r_cr[2]) - MW'(r_cr[3])) <<< 1;
        r_m[1][2] <= (MW'(r_cr[4]) - MW'(r_cr[5])) <<< 1;
        r_m[2][1] <= (MW'(r_cr[4]) + MW'(r_cr[5])) <<< 1;
    end

    assign o_ctl = r_ctl;
    assign o_n   = r_n;
    assign o_m   = r_m;
    assign o_v   = r_v2;
endmodule

// ===== hw/rtl/qvr_row.sv =====
// one matrix row times the vector, then sign split and rounding offset
module qvr_row (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qvr_pkg::t_ctl  i_ctl,
    input  qvr_pkg::t_norm i_n,
    input  qvr_pkg::t_ment i_m [3],
    input  qvr_pkg::t_vec  i_v [3],
    output qvr_pkg::t_ctl  o_ctl,
    output qvr_pkg::t_norm o_n,
    output qvr_pkg::t_mag  o_mag,
    output logic           o_neg
);
    import qvr_pkg::*;

    logic signed [PW-1:0] r_p [3];
    t_norm                r_n3, r_n4, r_n5;
    t_ctl                 r_ctl3, r_ctl4, r_ctl5;
    logic signed [AW-1:0] r_acc;
    logic        [AW-1:0] n_half;
    t_mag                 r_mag;
    logic                 r_neg;

    assign n_half = AW'(r_n4[NW-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
        end else begin
            r_ctl3 <= i_ctl;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
        end
        for (int j = 0; j < 3; j++) begin
            r_p[j] <= i_m[j] * i_v[j];
        end
        r_n3  <= i_n;
        r_acc <= AW'(r_p[0]) + AW'(r_p[1]) + AW'(r_p[2]);
        r_n4  <= r_n3;
        // magnitude plus half the divisor, so truncation rounds half away from zero
        r_neg <= r_acc[AW-1];
        r_mag <= r_acc[AW-1] ? GW'(~unsigned'(r_acc) + n_half + AW'(1))
                             : GW'(unsigned'(r_acc) + n_half);
        r_n5  <= r_n4;
    end

    assign o_ctl = r_ctl5;
    assign o_n   = r_n5;
    assign o_mag = r_mag;
    assign o_neg = r_neg;
endmodule

// ===== hw/rtl/qvr_divider.sv =====
// pipelined restoring divider, one quotient bit a stage, then sign and saturation
module qvr_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qvr_pkg::t_ctl  i_ctl,
    input  qvr_pkg::t_norm i_n,
    input  qvr_pkg::t_mag  i_mag,
    input  logic           i_neg,
    output qvr_pkg::t_ctl  o_ctl,
    output qvr_pkg::t_vec  o_rot,
    output logic           o_sat
);
    import qvr_pkg::*;

    logic [NW-1:0] r_rem [DIV_STEPS];
    logic [NW-1:0] r_low [DIV_STEPS];
    logic [NW-1:0] r_q   [DIV_STEPS];
    t_norm         r_n   [DIV_STEPS];
    logic          r_sg  [DIV_STEPS];
    t_ctl          r_ctl [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [NW-1:0] rem_in, low_in, q_in;
        t_norm         n_in;
        logic          sg_in;
        t_ctl          ctl_in;
        logic [NW:0]   trial;
        logic [NW:0]   diff;

        if (k == 0) begin : g_first
            // high bits of the dividend are below the divisor
            assign rem_in = i_mag[GW-1 -: NW];
            assign low_in = i_mag[NW-1:0];
            assign q_in   = '0;
            assign n_in   = i_n;
            assign sg_in  = i_neg;
            assign ctl_in = i_ctl;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
            assign n_in   = r_n[k-1];
            assign sg_in  = r_sg[k-1];
            assign ctl_in = r_ctl[k-1];
        end

        assign trial = {rem_in, low_in[NW-1]};
        assign diff  = trial - {1'b0, n_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= ctl_in;
            end
            if (trial >= {1'b0, n_in}) begin
                r_rem[k] <= diff[NW-1:0];
                r_q[k]   <= {q_in[NW-2:0], 1'b1};
            end else begin
                r_rem[k] <= trial[NW-1:0];
                r_q[k]   <= {q_in[NW-2:0], 1'b0};
            end
            r_low[k] <= {low_in[NW-2:0], 1'b0};
            r_n[k]   <= n_in;
            r_sg[k]  <= sg_in;
        end
    end

    localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);
    localparam logic [NW-1:0] POS_LIM = NW'(64'h7FFF_FFFF);

    logic [NW-1:0] quo;
    logic [NW-1:0] quo_neg;
    t_ctl          r_octl;
    t_vec          r_rot;
    logic          r_sat;

    assign quo     = r_q[DIV_STEPS-1];
    assign quo_neg = ~quo + NW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octl <= '0;
        end else begin
            r_octl <= r_ctl[DIV_STEPS-1];
        end
        if (r_ctl[DIV_STEPS-1].zero) begin
            r_rot <= '0;
            r_sat <= 1'b0;
        end else if (r_sg[DIV_STEPS-1]) begin
            r_sat <= (quo > NEG_LIM);
            r_rot <= (quo > NEG_LIM) ? VW'(NEG_LIM) : quo_neg[VW-1:0];
        end else begin
            r_sat <= (quo > POS_LIM);
            r_rot <= (quo > POS_LIM) ? VW'(POS_LIM) : quo[VW-1:0];
        end
    end

    assign o_ctl = r_octl;
    assign o_rot = r_rot;
    assign o_sat = r_sat;
endmodule
